/* sv/bcas_pkg.sv */
`timescale 1ns / 1ps
// Package for the binary cellular automaton smoothing unit.
// Holds field widths, register codes and reset values, and the result type.
// No dependencies.
package bcas_pkg;

  localparam int MAP_WIDTH_W  = 10;
  localparam int MAP_HEIGHT_W = 11;
  localparam int THRESH_W     = 4;
  localparam int ROW_OUT_W    = 10;
  localparam int COL_OUT_W    = 9;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;

  localparam logic [MAP_WIDTH_W-1:0]  MAP_WIDTH_RST  = 10'd300;
  localparam logic [MAP_HEIGHT_W-1:0] MAP_HEIGHT_RST = 11'd300;
  localparam logic [THRESH_W-1:0]     THRESH_RST     = 4'd5;
  localparam logic                    BORDER_RST     = 1'b1;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_MAP_WIDTH   = 2'd0,
    REG_MAP_HEIGHT  = 2'd1,
    REG_BIRTH_THR   = 2'd2,
    REG_BORDER_VAL  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                 smoothed;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] column;
    logic                 last;
  } res_t;

endpackage

/* sv/binary_cellular_automaton_smoothing_unit.sv */
`timescale 1ns / 1ps
// Top level of the binary cellular automaton smoothing unit.
// Depends on bcas_pkg.

// One smoothing pass over a raster-order bit map: each request carries one cell (or a
// drain item once the frame is complete), and the block accepts one request per clock
// cycle as long as the output side keeps taking results. The result for a cell leaves
// map_width+1 requests after the cell arrived, so map_width+1 drain requests after the
// last cell flush the frame; the result flagged last_of_frame ends it and the next
// request starts a new frame. The two previous rows live in a MAX_WIDTH x 2-bit memory
// with one write and one registered read port; the read of the next column is issued
// ahead of its use, and a bypass register covers the cases where the next request uses the
// entry just written: a one-cell-wide map and the restart after the last result of a
// frame. An output register plus one skid entry decouple the
// output: in_stall rises only when both hold a result. Any register write restarts the
// frame and must only happen while the block is idle.
module binary_cellular_automaton_smoothing_unit
  import bcas_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic                  in_cell_in,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_cell_out,
  output logic [ROW_OUT_W-1:0]  out_row,
  output logic [COL_OUT_W-1:0]  out_column,
  output logic                  out_last_of_frame
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int MWW = (WW > MAP_WIDTH_W) ? WW : MAP_WIDTH_W;
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int MHW = (HW > MAP_HEIGHT_W) ? HW : MAP_HEIGHT_W;

  // Configuration registers
  logic [MAP_WIDTH_W-1:0]  map_width_r;
  logic [MAP_HEIGHT_W-1:0] map_height_r;
  logic [THRESH_W-1:0]     birth_thr_r;
  logic                    border_r;

  // Frame state
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [8:0]    win_r, win_nxt;

  // Line store and its read side
  logic [1:0]    line_mem [MAX_WIDTH];
  logic [1:0]    rd_data_r;
  logic          fwd_r;
  logic [1:0]    fwd_data_r;

  // Output register and skid entry
  logic          out_valid_r, skid_valid_r;
  res_t          out_r, skid_r;

  logic          cfg_wr;
  cfg_reg_t      cfg_idx;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [RW-1:0] eff_h_ext;
  logic          take, past, step, cur, emit, last, col0, wrap;
  logic [1:0]    ls, wr_data;
  logic [2:0]    newcol, left, centre, right;
  logic          left_ok, right_ok, top_ok, bottom_ok;
  logic [RW-1:0] orow;
  logic [WW-1:0] ocol, col_inc;
  logic [7:0]    nb;
  logic [3:0]    count;
  res_t          res;
  logic          res_valid, out_fire;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_reg_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_MAP_WIDTH:  prdata = CFG_DATA_W'(map_width_r);
      REG_MAP_HEIGHT: prdata = CFG_DATA_W'(map_height_r);
      REG_BIRTH_THR:  prdata = CFG_DATA_W'(birth_thr_r);
      REG_BORDER_VAL: prdata = CFG_DATA_W'(border_r);
      default:        prdata = '0;
    endcase
  end

  // Clamp the map size to 1..MAX.
  always_comb begin
    if (map_width_r == '0) begin
      eff_w = WW'(1);
    end else if (MWW'(map_width_r) > MWW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(map_width_r);
    end
    if (map_height_r == '0) begin
      eff_h = HW'(1);
    end else if (MHW'(map_height_r) > MHW'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(map_height_r);
    end
  end
  assign eff_h_ext = RW'(eff_h);

  assign take = in_valid && !in_stall;
  assign past = row_r >= eff_h_ext;
  // A drain request is ignored while the frame still expects cells.
  assign step = take && (past || !in_operation);
  assign cur  = past ? border_r : in_cell_in;

  assign ls      = fwd_r ? fwd_data_r : rd_data_r;
  assign wr_data = {ls[0], cur};
  assign newcol  = {cur, ls[0], ls[1]};

  assign col0 = (col_r == '0);
  assign emit = (row_r >= RW'(2)) || ((row_r == RW'(1)) && !col0);
  assign last = (row_r == eff_h_ext + RW'(1)) && col0;

  // At column 0 the window still holds the end of the previous row, and the cell
  // being finished is the last one of that row, with nothing to its right.
  assign left     = win_r[5:3];
  assign centre   = win_r[8:6];
  assign right    = newcol;
  assign left_ok  = col0 ? (eff_w >= WW'(2)) : (col_r >= CW'(2));
  assign right_ok = !col0;
  assign orow     = col0 ? row_r - RW'(2) : row_r - RW'(1);
  assign ocol     = col0 ? eff_w - WW'(1) : WW'(col_r) - WW'(1);
  assign top_ok   = (orow != '0);
  assign bottom_ok = (orow + RW'(1)) < eff_h_ext;

  always_comb begin
    nb[0] = (left_ok && top_ok)     ? left[0]   : border_r;
    nb[1] = left_ok                 ? left[1]   : border_r;
    nb[2] = (left_ok && bottom_ok)  ? left[2]   : border_r;
    nb[3] = top_ok                  ? centre[0] : border_r;
    nb[4] = bottom_ok               ? centre[2] : border_r;
    nb[5] = (right_ok && top_ok)    ? right[0]  : border_r;
    nb[6] = right_ok                ? right[1]  : border_r;
    nb[7] = (right_ok && bottom_ok) ? right[2]  : border_r;
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + 4'(nb[i]);
    end
  end

  always_comb begin
    res.smoothed = (count >= birth_thr_r);
    res.row      = ROW_OUT_W'(orow);
    res.column   = COL_OUT_W'(ocol);
    res.last     = last;
  end
  assign res_valid = step && emit;

  assign col_inc = WW'(col_r) + WW'(1);
  assign wrap    = col_inc >= eff_w;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    win_nxt = win_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
      win_nxt = '0;
    end else if (step) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
        win_nxt = '0;
      end else begin
        win_nxt = {newcol, win_r[8:3]};
        if (wrap) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= MAP_WIDTH_RST;
      map_height_r <= MAP_HEIGHT_RST;
      birth_thr_r  <= THRESH_RST;
      border_r     <= BORDER_RST;
      col_r        <= '0;
      row_r        <= '0;
      win_r        <= '0;
      fwd_r        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_MAP_WIDTH:  map_width_r  <= pwdata[MAP_WIDTH_W-1:0];
          REG_MAP_HEIGHT: map_height_r <= pwdata[MAP_HEIGHT_W-1:0];
          REG_BIRTH_THR:  birth_thr_r  <= pwdata[THRESH_W-1:0];
          REG_BORDER_VAL: border_r     <= pwdata[0];
          default: ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      win_r <= win_nxt;
      // The memory returns the old entry when it is read and written at once.
      fwd_r <= step && (col_nxt == col_r);
    end
  end

  // Line store: written at the current column, read ahead at the next one.
  always_ff @(posedge clk) begin
    if (step) begin
      line_mem[col_r] <= wr_data;
    end
    rd_data_r  <= line_mem[col_nxt];
    fwd_data_r <= wr_data;
  end

  assign out_fire = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (res_valid && out_valid_r && !out_fire) begin
      skid_r <= res;
    end
  end

  assign in_stall          = skid_valid_r;
  assign out_valid         = out_valid_r;
  assign out_cell_out      = out_r.smoothed;
  assign out_row           = out_r.row;
  assign out_column        = out_r.column;
  assign out_last_of_frame = out_r.last;

endmodule

/* sv/bcas_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the smoothing unit, bound to the top level.
// Depends on bcas_pkg and binary_cellular_automaton_smoothing_unit.
module bcas_checker
  import bcas_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_cell_out,
  input logic [ROW_OUT_W-1:0] out_row,
  input logic [COL_OUT_W-1:0] out_column,
  input logic                 out_last_of_frame
);

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // The input side stalls only when a result was held on the output side.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a held result");

  // A result shows up only after a request was accepted.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an accepted request");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_out) && $stable(out_row)
      && $stable(out_column) && $stable(out_last_of_frame))
    else $error("stalled result changed");

endmodule

bind binary_cellular_automaton_smoothing_unit bcas_checker u_bcas_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_cell_out      (out_cell_out),
  .out_row           (out_row),
  .out_column        (out_column),
  .out_last_of_frame (out_last_of_frame)
);
